[hw/rtl/fractional_baud_divisor_macros.svh]
// Assertion helpers used by the checker file.
`ifndef FRACTIONAL_BAUD_DIVISOR_MACROS_SVH
`define FRACTIONAL_BAUD_DIVISOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fbd_pkg.sv]
package fbd_pkg;

  // Field widths
  localparam int unsigned BaudW   = 24;
  localparam int unsigned StoredW = 32;
  localparam int unsigned ClkW    = 32;
  localparam int unsigned DivW    = 27;
  localparam int unsigned MantW   = 23;
  localparam int unsigned RemW    = 10;
  localparam int unsigned FracW   = 4;

  // Dividend is clock_hz * 1000 / 16, which needs 38 bits; one cell per quotient bit
  localparam int unsigned DvdW    = 38;
  localparam int unsigned QuotW   = 32;

  localparam logic [9:0]  DecScale   = 10'd1000;
  localparam logic [8:0]  HalfScale  = 9'd500;

  // mant = (q * MantRecip) >> MantShift, exact for any 32-bit q
  localparam logic [28:0] MantRecip  = 29'd274877907;
  localparam int unsigned MantShift  = 38;

  // frac = (x * FracRecip) >> FracShift, exact for x below 16500
  localparam logic [14:0] FracRecip  = 15'd16778;
  localparam int unsigned FracShift  = 24;

  // Data carried along the divider chain
  typedef struct packed {
    logic [BaudW-1:0]   rem;     // partial remainder
    logic [DvdW-1:0]    dq;      // dividend bits left to use, quotient bits shifted in
    logic [BaudW-1:0]   baud;
    logic [StoredW-1:0] stored;
  } fbd_item_t;

endpackage

[hw/rtl/fbd_div_cell.sv]
module fbd_div_cell import fbd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  fbd_item_t item_i,
  output logic      valid_o,
  output fbd_item_t item_o
);

  logic [BaudW:0] shifted;
  logic [BaudW:0] diff;
  logic           ge;
  fbd_item_t      item_d;
  fbd_item_t      item_q;
  logic           valid_q;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  // A zero baud always fits, which yields an all-ones quotient.
  always_comb begin
    shifted = {item_i.rem, item_i.dq[DvdW-1]};
    diff    = shifted - {1'b0, item_i.baud};
    ge      = (shifted >= {1'b0, item_i.baud});
    item_d        = item_i;
    item_d.rem    = ge ? diff[BaudW-1:0] : shifted[BaudW-1:0];
    item_d.dq     = {item_i.dq[DvdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/fbd_fin.sv]
module fbd_fin import fbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fbd_item_t          item_i,
  output logic               valid_o,
  output logic [DivW-1:0]    divisor_o,
  output logic               mismatch_o,
  output logic               overflow_o
);

  logic [3:0] valid_q;

  // Stage 1: overflow check, mantissa by reciprocal multiply
  logic [QuotW-1:0]          q32;
  logic [60:0]               mant_prod;
  logic [QuotW-1:0]          s1_q_q;
  logic [MantW-1:0]          s1_mant_q;
  logic                      s1_ovf_q;
  logic [StoredW-1:0]        s1_stored_q;

  // Stage 2: remainder modulo 1000
  logic [32:0]               back_prod;
  logic [RemW-1:0]           rem;
  logic [RemW-1:0]           s2_rem_q;
  logic [MantW-1:0]          s2_mant_q;
  logic                      s2_ovf_q;
  logic [StoredW-1:0]        s2_stored_q;

  // Stage 3: rounded fraction, 0..16
  logic [14:0]               frac_x;
  logic [29:0]               frac_prod;
  logic [FracW:0]            s3_frac_q;
  logic [MantW-1:0]          s3_mant_q;
  logic                      s3_ovf_q;
  logic [StoredW-1:0]        s3_stored_q;

  // Stage 4: carry of a full fraction, compare, output register
  logic [MantW-1:0]          mant_f;
  logic [FracW-1:0]          frac_f;
  logic [DivW-1:0]           div_d;
  logic [DivW-1:0]           div_q;
  logic                      mismatch_q;
  logic                      ovf_q;

  always_comb begin
    q32       = item_i.dq[QuotW-1:0];
    mant_prod = 61'(q32) * 61'(MantRecip);
  end

  always_comb begin
    back_prod = 33'(s1_mant_q) * 33'(DecScale);
    rem       = s1_q_q[RemW-1:0] - back_prod[RemW-1:0];
  end

  // (rem*16 + 500) / 1000 gives the fraction already rounded half up
  always_comb begin
    frac_x    = {1'b0, s2_rem_q, 4'b0000} + 15'(HalfScale);
    frac_prod = 30'(frac_x) * 30'(FracRecip);
  end

  always_comb begin
    mant_f = s3_mant_q + MantW'(s3_frac_q[FracW]);
    frac_f = s3_frac_q[FracW] ? '0 : s3_frac_q[FracW-1:0];
    div_d  = {mant_f, frac_f};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q_q      <= q32;
      s1_mant_q   <= mant_prod[MantShift +: MantW];
      s1_ovf_q    <= |item_i.dq[DvdW-1:QuotW];
      s1_stored_q <= item_i.stored;

      s2_rem_q    <= rem;
      s2_mant_q   <= s1_mant_q;
      s2_ovf_q    <= s1_ovf_q;
      s2_stored_q <= s1_stored_q;

      s3_frac_q   <= frac_prod[FracShift +: (FracW + 1)];
      s3_mant_q   <= s2_mant_q;
      s3_ovf_q    <= s2_ovf_q;
      s3_stored_q <= s2_stored_q;

      div_q       <= div_d;
      mismatch_q  <= (s3_stored_q != {{(StoredW-DivW){1'b0}}, div_d});
      ovf_q       <= s3_ovf_q;
    end
  end

  assign valid_o    = valid_q[3];
  assign divisor_o  = div_q;
  assign mismatch_o = mismatch_q;
  assign overflow_o = ovf_q;

endmodule

[hw/rtl/fractional_baud_divisor.sv]
// Fractional baud divisor for a 16x-oversampling UART. Each request carries a
// baud rate and the divisor currently programmed; the result is the divisor
// (mantissa << 4 | four-bit fraction, rounded half up) for the clock rate held
// in the clock_hz register, a flag telling whether it differs from the stored
// one, and a flag telling that the quotient clock*1000/(baud*16) exceeded 32
// bits (a zero baud rate counts as overflow). A new request is taken every
// cycle unless the pipeline holds; a result passes through the entry register
// for the clock*1000 product, 38 cells of the divider chain (one quotient bit
// each), three finishing stages and the output register. The whole pipeline
// holds while a result sits stalled at the output. Write clock_hz only with
// no requests in flight.
module fractional_baud_divisor import fbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ClkW-1:0]    cfg_clock_hz_i,
  // requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [BaudW-1:0]   baud_rate_i,
  input  logic [StoredW-1:0] stored_divisor_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DivW-1:0]    divisor_o,
  output logic               mismatch_o,
  output logic               overflow_o
);

  localparam logic [ClkW-1:0] ClockHzReset = 32'd50000000;

  logic [ClkW-1:0]  clock_hz_q;
  logic             en;
  logic [41:0]      num;
  logic             m_valid_q;
  fbd_item_t        m_item_q;
  logic [DvdW:0]    chain_valid;
  fbd_item_t        chain_item [DvdW+1];

  // Clock rate register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q <= ClockHzReset;
    end else if (cfg_valid_i) begin
      clock_hz_q <= cfg_clock_hz_i;
    end
  end

  // Pipeline advances unless a result is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Entry stage: dividend = clock*1000/16, dividing by baud*16 equals this by baud
  assign num = 42'(clock_hz_q) * 42'(DecScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_item_q.rem    <= '0;
      m_item_q.dq     <= num[41:4];
      m_item_q.baud   <= baud_rate_i;
      m_item_q.stored <= stored_divisor_i;
    end
  end

  // Divider chain, one quotient bit per cell
  assign chain_valid[0] = m_valid_q;
  assign chain_item[0]  = m_item_q;

  for (genvar i = 0; i < DvdW; i++) begin : g_cell
    fbd_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[i]),
      .item_i  (chain_item[i]),
      .valid_o (chain_valid[i+1]),
      .item_o  (chain_item[i+1])
    );
  end

  // Mantissa, fraction, compare, output register
  fbd_fin u_fin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (chain_valid[DvdW]),
    .item_i     (chain_item[DvdW]),
    .valid_o    (out_valid_o),
    .divisor_o  (divisor_o),
    .mismatch_o (mismatch_o),
    .overflow_o (overflow_o)
  );

endmodule

[hw/rtl/fbd_checker.sv]
`include "fractional_baud_divisor_macros.svh"

module fbd_checker import fbd_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [ClkW-1:0]    cfg_clock_hz_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [BaudW-1:0]   baud_rate_i,
  input logic [StoredW-1:0] stored_divisor_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [DivW-1:0]    divisor_o,
  input logic               mismatch_o,
  input logic               overflow_o
);

  // A stalled result stays put
  `FBD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(divisor_o) && $stable(mismatch_o) && $stable(overflow_o), "result changed while stalled")

  // Requests are held off only while a result is stuck at the output
  `FBD_ASSERT_NOW(a_in_stall, 1'b1, in_stall_o == (out_valid_o && out_stall_i), "request stall without output back-pressure")

  // Mantissa of a 32-bit quotient over 1000, plus a possible carry
  `FBD_ASSERT_NOW(a_mant_range, out_valid_o, divisor_o[DivW-1:FracW] <= 23'd4294968, "mantissa out of range")

endmodule

bind fractional_baud_divisor fbd_checker u_fbd_checker (.*);
